FILE: hdl/adam_pkg.sv
// ----------------------------------------------------------------------------
// adam_pkg: shared types, constants and arithmetic helpers
// Register codes, configuration and stage records, and the one-bit divide,
// square-root and saturation steps of the Adam update datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package adam_pkg;

  // element store geometry (power of two: the index wraps on its low bits)
  localparam int ELEMENTS = 1024;
  localparam int ADDR_W   = $clog2(ELEMENTS);
  localparam int IDX_W    = 10;
  localparam int DATA_W   = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 3'd4;

  localparam logic [23:0] LR_RST    = 24'd16777;
  localparam logic [15:0] B1_RST    = 16'd58982;
  localparam logic [15:0] B2_RST    = 16'd65470;
  localparam logic [31:0] EPS_RST   = 32'd43;
  localparam logic [15:0] DECAY_RST = 16'd0;

  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
  localparam logic [33:0] DELTA_CAP = 34'h2_0000_0000;

  localparam logic signed [50:0] SAT_HI = 51'sd2147483647;
  localparam logic signed [50:0] SAT_LO = -51'sd2147483648;

  typedef struct packed {
    logic [23:0] lr;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [31:0] eps;
    logic [15:0] decay;
  } cfg_t;

  // moment stage result handed to the scaling pipeline
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] p;
    logic [31:0]       m;
    logic [63:0]       v;
    logic [31:0]       c1;
    logic [31:0]       c2;
  } mom_t;

  // finished request
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] np;
  } res_t;

  // clamp to signed 32 bit
  function automatic logic [31:0] sat32(input logic signed [50:0] x);
    logic [31:0] r;
    if (x > SAT_HI) begin
      r = 32'h7fff_ffff;
    end else if (x < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // one restoring divide step: {quotient bit, new remainder}
  function automatic logic [50:0] div_step(input logic [49:0] rem, input logic [49:0] d,
                                           input logic nb);
    logic [50:0] t;
    logic [50:0] r;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      r = t - {1'b0, d};
      r[50] = 1'b1;
    end else begin
      r = t;
      r[50] = 1'b0;
    end
    return r;
  endfunction

  // one digit of integer square root: {new root, new remainder}
  function automatic logic [97:0] sqrt_step(input logic [49:0] rem, input logic [47:0] root,
                                            input logic [1:0] nb);
    logic [51:0] t;
    logic [51:0] trial;
    logic [97:0] r;
    t     = {rem, nb};
    trial = {2'b00, root, 2'b01};
    if (t >= trial) begin
      r = {root[46:0], 1'b1, 50'(t - trial)};
    end else begin
      r = {root[46:0], 1'b0, t[49:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/adam_optimizer_update.sv
// ----------------------------------------------------------------------------
// adam_optimizer_update: fixed-point Adam update, one element per request
// Configuration registers, moment pipeline, scaling pipeline and a
// two-entry output buffer.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   --------------------------------------------
//   cfg       cfg_we               cfg_index, cfg_data
//   in        in_valid / in_ready  element_index, gradient, param_value,
//                                  first_of_step
//   out       out_valid/out_ready  out_index, new_param
//
// One request per cycle sustained while the output drains; a result passes
// through the moment pipeline, the 64-step bias-correction dividers, the
// 48-step square root and the 34-step step divider into the output register
// and can leave on the next edge.
// After reset the moment store is cleared one entry a cycle: in_ready stays
// low until all 1024 entries are cleared. Config writes are taken at any time.
// A stalled output holds the whole pipeline; two results can wait in the
// output buffer before in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_optimizer_update (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [adam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [adam_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [adam_pkg::IDX_W-1:0]     element_index,
  input  wire logic signed [31:0]             gradient,
  input  wire logic signed [31:0]             param_value,
  input  wire logic                           first_of_step,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [adam_pkg::IDX_W-1:0]          out_index,
  output logic signed [31:0]                  new_param
);
  import adam_pkg::*;

  cfg_t       cfg;
  mom_t       mom;
  res_t       res;
  logic       busy;
  logic       en;
  logic       take;
  logic       push;
  logic       pop;
  logic [1:0] ocnt;
  res_t       ob0;
  res_t       ob1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lr    <= LR_RST;
      cfg.b1    <= B1_RST;
      cfg.b2    <= B2_RST;
      cfg.eps   <= EPS_RST;
      cfg.decay <= DECAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LR:    cfg.lr    <= cfg_data[23:0];
        REG_B1:    cfg.b1    <= cfg_data[15:0];
        REG_B2:    cfg.b2    <= cfg_data[15:0];
        REG_EPS:   cfg.eps   <= cfg_data;
        REG_DECAY: cfg.decay <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless both output slots are held
  assign en       = (ocnt != 2'd2) || out_ready;
  assign in_ready = en && !busy;
  assign take     = in_valid && in_ready;

  adam_moment u_moment (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .cfg   (cfg),
    .take  (take),
    .idx   (element_index),
    .grad  (gradient),
    .param (param_value),
    .first (first_of_step),
    .busy  (busy),
    .mom   (mom)
  );

  adam_scale u_scale (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .cfg (cfg),
    .mom (mom),
    .res (res)
  );

  // two-entry output buffer
  assign push = en && res.vld;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else begin
      ocnt <= ocnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (ocnt == 2'd0) begin
          ob0 <= res;
        end else begin
          ob1 <= res;
        end
      end
      2'b01: begin
        ob0 <= ob1;
      end
      2'b11: begin
        if (ocnt == 2'd1) begin
          ob0 <= res;
        end else begin
          ob0 <= ob1;
          ob1 <= res;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = (ocnt != 2'd0);
  assign out_index = ob0.idx;
  assign new_param = $signed(ob0.np);

endmodule

`default_nettype wire

FILE: hdl/adam_ram.sv
// ----------------------------------------------------------------------------
// adam_ram: generic single-clock RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/adam_moment.sv
// ----------------------------------------------------------------------------
// adam_moment: weight decay, moment read-modify-write and beta powers
// Five stages; the moment store is read from stage 3, ahead of the update in
// stage 4; the previous update is forwarded when it hits the same element.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_moment (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire adam_pkg::cfg_t             cfg,
  input  wire logic                       take,
  input  wire logic [adam_pkg::IDX_W-1:0] idx,
  input  wire logic signed [31:0]         grad,
  input  wire logic signed [31:0]         param,
  input  wire logic                       first,
  output logic                            busy,
  output adam_pkg::mom_t                  mom
);
  import adam_pkg::*;

  logic [31:0]        pow1;
  logic [31:0]        pow2;
  logic [47:0]        pow1_prod;
  logic [47:0]        pow2_prod;
  logic [ADDR_W:0]    clr_cnt;
  logic signed [48:0] dprod;

  logic               s1_vld;
  logic [IDX_W-1:0]   s1_idx;
  logic signed [31:0] s1_g;
  logic [31:0]        s1_p;
  logic signed [48:0] s1_dprod;

  logic signed [50:0] gsum;
  logic [31:0]        c1_raw;
  logic [31:0]        c2_raw;

  logic               s2_vld;
  logic [IDX_W-1:0]   s2_idx;
  logic signed [31:0] s2_g;
  logic [31:0]        s2_p;
  logic [31:0]        s2_c1;
  logic [31:0]        s2_c2;

  logic [16:0]        nb1;
  logic [16:0]        nb2;
  logic [31:0]        gmag;

  logic               s3_vld;
  logic [IDX_W-1:0]   s3_idx;
  logic [31:0]        s3_p;
  logic [31:0]        s3_c1;
  logic [31:0]        s3_c2;
  logic signed [48:0] s3_gm;
  logic [63:0]        s3_g2;

  logic               s4_vld;
  logic [IDX_W-1:0]   s4_idx;
  logic [31:0]        s4_p;
  logic [31:0]        s4_c1;
  logic [31:0]        s4_c2;
  logic signed [48:0] s4_gm;
  logic [48:0]        s4_gvh;
  logic [48:0]        s4_gvl;

  logic               fwd;
  logic [95:0]        rd_data;
  logic [95:0]        wr_data;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [31:0]        m_old;
  logic [63:0]        v_old;
  logic signed [48:0] mprod;
  logic signed [49:0] msum;
  logic [31:0]        m_new;
  logic [49:0]        hsum;
  logic [49:0]        lsum;
  logic [64:0]        vsum;
  logic [63:0]        v_new;

  // clearing pass over the moment store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (!clr_cnt[ADDR_W]) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end
  assign busy = !clr_cnt[ADDR_W];

  // running beta powers, advanced by the first request of a step
  assign pow1_prod = 48'(pow1) * 48'(cfg.b1);
  assign pow2_prod = 48'(pow2) * 48'(cfg.b2);
  always_ff @(posedge clk) begin
    if (rst) begin
      pow1 <= ONE_Q31;
      pow2 <= ONE_Q31;
    end else if (take && first) begin
      pow1 <= pow1_prod[47:16];
      pow2 <= pow2_prod[47:16];
    end
  end

  // stage 1: capture request, weight decay product
  assign dprod = 49'(param) * 49'($signed({1'b0, cfg.decay}));
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld   <= take;
      s1_idx   <= idx;
      s1_g     <= grad;
      s1_p     <= param;
      s1_dprod <= dprod;
    end
  end

  // stage 2: decayed gradient, bias correction terms
  assign gsum   = 51'(s1_g) + 51'(s1_dprod >>> 16);
  assign c1_raw = ONE_Q31 - pow1;
  assign c2_raw = ONE_Q31 - pow2;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
      s2_idx <= s1_idx;
      s2_g   <= (cfg.decay != 16'd0) ? $signed(sat32(gsum)) : s1_g;
      s2_p   <= s1_p;
      s2_c1  <= (c1_raw == 32'd0) ? ONE_Q31 : c1_raw;
      s2_c2  <= (c2_raw == 32'd0) ? ONE_Q31 : c2_raw;
    end
  end

  // stage 3: gradient share of first moment, gradient square
  assign nb1  = 17'h1_0000 - {1'b0, cfg.b1};
  assign nb2  = 17'h1_0000 - {1'b0, cfg.b2};
  assign gmag = s2_g[31] ? (~s2_g + 32'd1) : s2_g;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
      s3_idx <= s2_idx;
      s3_p   <= s2_p;
      s3_c1  <= s2_c1;
      s3_c2  <= s2_c2;
      s3_gm  <= 49'(s2_g) * 49'($signed({1'b0, nb1}));
      s3_g2  <= 64'(gmag) * 64'(gmag);
    end
  end

  // stage 4: gradient share of second moment, store read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
      s4_idx <= s3_idx;
      s4_p   <= s3_p;
      s4_c1  <= s3_c1;
      s4_c2  <= s3_c2;
      s4_gm  <= s3_gm;
      s4_gvh <= 49'(s3_g2[63:32]) * 49'(nb2);
      s4_gvl <= 49'(s3_g2[31:0]) * 49'(nb2);
    end
  end

  // moment store: first moment in the upper word, second in the lower
  adam_ram #(
    .WIDTH (96),
    .DEPTH (ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_data),
    .re    (en),
    .raddr (s3_idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // forward the update just written when it hits the same element
  assign fwd   = mom.vld && (mom.idx == s4_idx);
  assign m_old = fwd ? mom.m : rd_data[95:64];
  assign v_old = fwd ? mom.v : rd_data[63:0];

  // first moment update
  assign mprod = 49'($signed(m_old)) * 49'($signed({1'b0, cfg.b1}));
  assign msum  = 50'(mprod) + 50'(s4_gm);
  assign m_new = sat32(51'(msum >>> 16));

  // second moment update, saturating
  assign hsum  = 50'(v_old[63:32]) * 50'(cfg.b2) + 50'(s4_gvh);
  assign lsum  = 50'(v_old[31:0]) * 50'(cfg.b2) + 50'(s4_gvl);
  assign vsum  = 65'({hsum[47:0], 16'h0000}) + 65'(lsum[49:16]);
  assign v_new = ((hsum[49:48] != 2'b00) || vsum[64]) ? 64'hffff_ffff_ffff_ffff : vsum[63:0];

  // store write: clearing pass or write-back
  assign we      = busy || (en && s4_vld);
  assign waddr   = busy ? clr_cnt[ADDR_W-1:0] : s4_idx[ADDR_W-1:0];
  assign wr_data = busy ? 96'd0 : {m_new, v_new};

  // stage 5: updated moments out
  always_ff @(posedge clk) begin
    if (rst) begin
      mom.vld <= 1'b0;
    end else if (en) begin
      mom.vld <= s4_vld;
      mom.idx <= s4_idx;
      mom.p   <= s4_p;
      mom.m   <= m_new;
      mom.v   <= v_new;
      mom.c1  <= s4_c1;
      mom.c2  <= s4_c2;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/adam_scale.sv
// ----------------------------------------------------------------------------
// adam_scale: bias correction, square root and step division
// Pipelined one bit per stage: two 64-step dividers side by side, a 48-step
// square root, a split multiply and sum, a 34-step divider, then the final add.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_scale (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire adam_pkg::cfg_t cfg,
  input  wire adam_pkg::mom_t mom,
  output adam_pkg::res_t      res
);
  import adam_pkg::*;

  localparam int V_STEPS = 64;
  localparam int S_STEPS = 48;
  localparam int D_STEPS = 34;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] p;
    logic              neg;
    logic [31:0]       mag;
    logic [31:0]       c1;
    logic [31:0]       mrem;
    logic [63:0]       mq;
    logic [32:0]       vlow;
    logic              vovf;
    logic [31:0]       c2;
    logic [31:0]       vrem;
    logic [63:0]       vq;
  } vst_t;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] p;
    logic              neg;
    logic [62:0]       mh;
    logic [63:0]       vh;
    logic [49:0]       srem;
    logic [47:0]       sroot;
  } sst_t;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] p;
    logic              neg;
    logic [48:0]       den;
    logic [55:0]       plo;
    logic [54:0]       phi;
  } est_t;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] p;
    logic              neg;
    logic [48:0]       den;
    logic [86:0]       sum;
  } ast_t;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] p;
    logic              neg;
    logic [33:0]       dnum;
    logic [48:0]       den;
    logic              dovf;
    logic [48:0]       rem;
    logic [33:0]       q;
  } dst_t;

  vst_t               v_init;
  vst_t               vs [V_STEPS];
  sst_t               s_init;
  sst_t               ss [S_STEPS];
  est_t               e1;
  ast_t               e2;
  logic [48:0]        den_raw;
  dst_t               d_init;
  dst_t               ds [D_STEPS];
  logic [33:0]        delta;
  logic signed [35:0] psx;
  logic signed [35:0] dsx;
  logic signed [35:0] np;

  // divider entry: magnitude of m, second moment overflow check
  always_comb begin
    v_init      = '0;
    v_init.vld  = mom.vld;
    v_init.idx  = mom.idx;
    v_init.p    = mom.p;
    v_init.neg  = mom.m[31];
    v_init.mag  = mom.m[31] ? (~mom.m + 32'd1) : mom.m;
    v_init.c1   = mom.c1;
    v_init.vlow = mom.v[32:0];
    v_init.vovf = ({1'b0, mom.v[63:33]} >= mom.c2);
    v_init.c2   = mom.c2;
    v_init.vrem = v_init.vovf ? 32'd0 : {1'b0, mom.v[63:33]};
  end

  // m_hat and v_hat dividers, one quotient bit per stage
  for (genvar k = 0; k < V_STEPS; k++) begin : g_vdiv
    vst_t        src;
    vst_t        nxt;
    logic [63:0] mnum;
    logic [63:0] vnum;
    logic [50:0] mstep;
    logic [50:0] vstep;

    if (k == 0) begin : g_first
      assign src = v_init;
    end else begin : g_next
      assign src = vs[k-1];
    end

    assign mnum  = {1'b0, src.mag, 31'd0};
    assign vnum  = {src.vlow, 31'd0};
    assign mstep = div_step(50'(src.mrem), 50'(src.c1), mnum[V_STEPS-1-k]);
    assign vstep = div_step(50'(src.vrem), 50'(src.c2), vnum[V_STEPS-1-k]);

    always_comb begin
      nxt      = src;
      nxt.mrem = mstep[31:0];
      nxt.mq   = {src.mq[62:0], mstep[50]};
      nxt.vrem = vstep[31:0];
      nxt.vq   = {src.vq[62:0], vstep[50]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k].vld <= 1'b0;
      end else if (en) begin
        vs[k] <= nxt;
      end
    end
  end

  // square root entry
  always_comb begin
    s_init     = '0;
    s_init.vld = vs[V_STEPS-1].vld;
    s_init.idx = vs[V_STEPS-1].idx;
    s_init.p   = vs[V_STEPS-1].p;
    s_init.neg = vs[V_STEPS-1].neg;
    s_init.mh  = vs[V_STEPS-1].mq[62:0];
    s_init.vh  = vs[V_STEPS-1].vovf ? 64'hffff_ffff_ffff_ffff : vs[V_STEPS-1].vq;
  end

  // square root of v_hat scaled by 2^32, one root bit per stage
  for (genvar k = 0; k < S_STEPS; k++) begin : g_sqrt
    sst_t        src;
    sst_t        nxt;
    logic [95:0] x;
    logic [97:0] sstep;

    if (k == 0) begin : g_first
      assign src = s_init;
    end else begin : g_next
      assign src = ss[k-1];
    end

    assign x     = {src.vh, 32'd0};
    assign sstep = sqrt_step(src.srem, src.sroot, x[95-2*k -: 2]);

    always_comb begin
      nxt       = src;
      nxt.sroot = sstep[97:50];
      nxt.srem  = sstep[49:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ss[k].vld <= 1'b0;
      end else if (en) begin
        ss[k] <= nxt;
      end
    end
  end

  // denominator and split numerator multiply
  assign den_raw = 49'(ss[S_STEPS-1].sroot) + 49'(cfg.eps);
  always_ff @(posedge clk) begin
    if (rst) begin
      e1.vld <= 1'b0;
    end else if (en) begin
      e1.vld <= ss[S_STEPS-1].vld;
      e1.idx <= ss[S_STEPS-1].idx;
      e1.p   <= ss[S_STEPS-1].p;
      e1.neg <= ss[S_STEPS-1].neg;
      e1.den <= (den_raw == 49'd0) ? 49'd1 : den_raw;
      e1.plo <= 56'(ss[S_STEPS-1].mh[31:0]) * 56'(cfg.lr);
      e1.phi <= 55'(ss[S_STEPS-1].mh[62:32]) * 55'(cfg.lr);
    end
  end

  // numerator sum
  always_ff @(posedge clk) begin
    if (rst) begin
      e2.vld <= 1'b0;
    end else if (en) begin
      e2.vld <= e1.vld;
      e2.idx <= e1.idx;
      e2.p   <= e1.p;
      e2.neg <= e1.neg;
      e2.den <= e1.den;
      e2.sum <= {e1.phi, 32'd0} + 87'(e1.plo);
    end
  end

  // step divider entry: quotient at or above 2^34 is capped outright
  always_comb begin
    d_init      = '0;
    d_init.vld  = e2.vld;
    d_init.idx  = e2.idx;
    d_init.p    = e2.p;
    d_init.neg  = e2.neg;
    d_init.den  = e2.den;
    d_init.dnum = {e2.sum[25:0], 8'd0};
    d_init.dovf = (e2.sum[86:26] >= 61'(e2.den));
    d_init.rem  = d_init.dovf ? 49'd0 : e2.sum[74:26];
  end

  // step divider, one quotient bit per stage
  for (genvar k = 0; k < D_STEPS; k++) begin : g_ddiv
    dst_t        src;
    dst_t        nxt;
    logic [50:0] dstep;

    if (k == 0) begin : g_first
      assign src = d_init;
    end else begin : g_next
      assign src = ds[k-1];
    end

    assign dstep = div_step(50'(src.rem), 50'(src.den), src.dnum[D_STEPS-1-k]);

    always_comb begin
      nxt     = src;
      nxt.rem = dstep[48:0];
      nxt.q   = {src.q[32:0], dstep[50]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ds[k].vld <= 1'b0;
      end else if (en) begin
        ds[k] <= nxt;
      end
    end
  end

  // capped step applied against the sign of m
  assign delta = (ds[D_STEPS-1].dovf || (ds[D_STEPS-1].q > DELTA_CAP)) ?
                 DELTA_CAP : ds[D_STEPS-1].q;
  assign psx   = 36'($signed(ds[D_STEPS-1].p));
  assign dsx   = $signed({2'b00, delta});
  assign np    = ds[D_STEPS-1].neg ? (psx + dsx) : (psx - dsx);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.vld <= 1'b0;
    end else if (en) begin
      res.vld <= ds[D_STEPS-1].vld;
      res.idx <= ds[D_STEPS-1].idx;
      res.np  <= sat32(51'(np));
    end
  end

endmodule

`default_nettype wire

FILE: hdl/adam_checker.sv
// ----------------------------------------------------------------------------
// adam_checker: port-level checks for the Adam update block
// Reset behavior, request and result hold under stall and input readiness
// when drained.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic [adam_pkg::IDX_W-1:0]      element_index,
  input wire logic signed [31:0]              gradient,
  input wire logic signed [31:0]              param_value,
  input wire logic                            first_of_step,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [adam_pkg::IDX_W-1:0]      out_index,
  input wire logic signed [31:0]              new_param
);

  // reset starts the clearing pass with nothing buffered
  a_reset_idle: assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("request accepted or result shown right after reset");

  // a waiting request stays put
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(element_index) && $stable(gradient)
      && $stable(param_value) && $stable(first_of_step))
    else $error("request changed while waiting");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(new_param))
    else $error("result changed while stalled");

  // once ready, an empty output never blocks new requests
  a_ready_drained: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(in_ready) && !out_valid |-> in_ready)
    else $error("input blocked with empty output buffer");

endmodule

bind adam_optimizer_update adam_checker u_checker (.*);

`default_nettype wire
